@@ rtl/cddb_pkg.sv @@
// cddb_pkg: shared types, widths and constants of the disc identifier block
// holds reciprocal constants for the divide-by-constant steps and the digit-sum helper
// no dependencies
`default_nettype none

package cddb_pkg;

  // block constants
  localparam int SECTORS_PER_SECOND = 75;
  localparam int MAX_TRACKS         = 99;
  localparam int ID_MODULUS         = 255;
  localparam int DEC_TEN            = 10;
  localparam int DEC_HUNDRED        = 100;
  localparam int DEC_MYRIAD         = 10000;

  // field widths
  localparam int SECTOR_W = 19;
  localparam int OFFSET_W = 9;
  localparam int ID_W     = 32;
  localparam int COUNT_W  = 7;
  localparam int DT_W     = 12;
  localparam int FIRST_W  = 13;
  localparam int PLAY_W   = 16;
  localparam int CHK_W    = 8;

  // sector plus offset
  localparam longint unsigned SUM_MAX = (64'd1 << SECTOR_W) - 1 + (64'd1 << OFFSET_W) - 1;
  localparam int SUM_W = $clog2(SUM_MAX + 1);

  // seconds = sum / SECTORS_PER_SECOND by reciprocal multiply
  localparam longint unsigned SEC_MAX = SUM_MAX / SECTORS_PER_SECOND;
  localparam int SEC_W     = $clog2(SEC_MAX + 1);
  localparam int SEC_SHIFT = SUM_W + $clog2(SECTORS_PER_SECOND);
  localparam longint unsigned SEC_RECIP =
    ((64'd1 << SEC_SHIFT) + SECTORS_PER_SECOND - 1) / SECTORS_PER_SECOND;
  localparam int SEC_RECIP_W = SUM_W + 1;

  // seconds / 100 and seconds / 10000 by reciprocal multiply
  localparam int HUND_SHIFT = SEC_W + 7;
  localparam longint unsigned HUND_RECIP =
    ((64'd1 << HUND_SHIFT) + DEC_HUNDRED - 1) / DEC_HUNDRED;
  localparam int MYR_SHIFT = SEC_W + 14;
  localparam longint unsigned MYR_RECIP =
    ((64'd1 << MYR_SHIFT) + DEC_MYRIAD - 1) / DEC_MYRIAD;
  localparam int HUND_W = $clog2(SEC_MAX / DEC_HUNDRED + 1);
  localparam int DIG2_W = 7;
  localparam int WK_W   = SEC_W + 8;

  typedef logic [SECTOR_W-1:0]          sector_t;
  typedef logic [OFFSET_W-1:0]          offset_t;
  typedef logic [SUM_W-1:0]             sum_t;
  typedef logic [SEC_W-1:0]             sec_t;
  typedef logic [SUM_W+SEC_RECIP_W-1:0] sec_prod_t;
  typedef logic [2*SEC_W:0]             dec_prod_t;
  typedef logic [HUND_W-1:0]            hund_t;
  typedef logic [DIG2_W-1:0]            dig2_t;
  typedef logic [WK_W-1:0]              wk_t;
  typedef logic [4:0]                   dsum2_t;
  typedef logic [5:0]                   dsum_t;
  typedef logic [DT_W-1:0]              dt_t;
  typedef logic [FIRST_W-1:0]           first_t;
  typedef logic [COUNT_W-1:0]           count_t;
  typedef logic [PLAY_W-1:0]            play_t;
  typedef logic [SEC_W+PLAY_W-1:0]      pw_t;
  typedef logic [CHK_W-1:0]             chk_t;
  typedef logic [CHK_W:0]               chk_sum_t;
  typedef logic [ID_W-1:0]              id_t;

  // digit sum of a value below one hundred, no division
  function automatic dsum2_t digit_sum2(input dig2_t v);
    logic [3:0] tens;
    dig2_t      ones;
    tens = '0;
    for (int k = 1; k < DEC_TEN; k++) begin
      if (v >= dig2_t'(k * DEC_TEN)) tens = 4'(k);
    end
    ones = v - dig2_t'(tens) * dig2_t'(DEC_TEN);
    return dsum2_t'(tens) + dsum2_t'(ones);
  endfunction

endpackage

`default_nettype wire

@@ rtl/cddb_cfg_if.sv @@
// cddb_cfg_if: configuration write channel carrying the sector offset
// depends on cddb_pkg
`default_nettype none

interface cddb_cfg_if;
  logic              valid;
  logic              ready;
  cddb_pkg::offset_t sector_offset;

  modport source (output valid, output sector_offset, input ready);
  modport sink   (input valid, input sector_offset, output ready);
endinterface

`default_nettype wire

@@ rtl/cddb_in_if.sv @@
// cddb_in_if: table-of-contents entry channel
// depends on cddb_pkg
`default_nettype none

interface cddb_in_if;
  logic              valid;
  logic              ready;
  cddb_pkg::sector_t start_sector;
  logic              is_leadout;

  modport source (output valid, output start_sector, output is_leadout, input ready);
  modport sink   (input valid, input start_sector, input is_leadout, output ready);
endinterface

`default_nettype wire

@@ rtl/cddb_out_if.sv @@
// cddb_out_if: disc identifier result channel
// depends on cddb_pkg
`default_nettype none

interface cddb_out_if;
  logic             valid;
  logic             ready;
  cddb_pkg::id_t    disc_id;
  cddb_pkg::count_t track_total;
  logic             overflow;

  modport source (output valid, output disc_id, output track_total, output overflow,
                  input ready);
  modport sink   (input valid, input disc_id, input track_total, input overflow,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/cddb_disc_id.sv @@
// cddb_disc_id: computes the CDDB-style disc identifier from table-of-contents beats
// depends on cddb_pkg, cddb_cfg_if, cddb_in_if and cddb_out_if
`default_nettype none

// Feed the track start sectors of one disc in order, then the lead-out sector with
// is_leadout set; only the lead-out beat returns a result (disc_id, track_total,
// overflow), after which the per-disc state clears for the next disc. The block takes
// one beat per cycle; each beat passes four registered stages (offset add, seconds
// divide, decimal split, digit sum) and the lead-out result then goes into the output
// register. Bubbles in those stages absorb beats while a result waits on the output,
// so input stalls only once the stages fill.
// Write sector_offset (150 for standard discs) only while no disc is in flight.
module cddb_disc_id (
  input  wire logic       clk,
  input  wire logic       rst_n,
  cddb_cfg_if.sink        cfg_ch,
  cddb_in_if.sink         in_ch,
  cddb_out_if.source      out_ch
);

  // configuration
  cddb_pkg::offset_t offset_r;

  // stage valids and lead-out flags
  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r;
  logic s1_lo_r, s2_lo_r, s3_lo_r, s4_lo_r;

  // stage payloads
  cddb_pkg::sum_t    s1_sum_r;
  cddb_pkg::sec_t    s2_sec_r;
  cddb_pkg::sec_t    s3_sec_r;
  cddb_pkg::hund_t   s3_hund_r;
  cddb_pkg::dig2_t   s3_myr_r;
  cddb_pkg::sec_t    s4_sec_r;
  cddb_pkg::dsum_t   s4_dsum_r;

  // per-disc state
  cddb_pkg::dt_t     digit_total_r, digit_total_nxt;
  cddb_pkg::first_t  first_sec_r, first_sec_nxt;
  cddb_pkg::count_t  track_count_r, track_count_nxt;
  logic              too_many_r, too_many_nxt;

  // output register
  logic              out_vld_r;
  cddb_pkg::id_t     out_id_r, out_id_nxt;
  cddb_pkg::count_t  out_total_r;
  logic              out_ovf_r;

  // flow control
  logic out_free, s4_go, rdy1, rdy2, rdy3, rdy4;

  // combinational datapath
  cddb_pkg::sec_prod_t sec_prod;
  cddb_pkg::dec_prod_t hund_prod, myr_prod;
  cddb_pkg::dig2_t     dig_lo, dig_mid;
  cddb_pkg::dsum_t     dsum;
  cddb_pkg::chk_sum_t  chk_fold;
  cddb_pkg::chk_t      chk;
  cddb_pkg::play_t     play;

  // ready chain: a stage loads when it is empty or its content moves on
  assign out_free = !out_vld_r || out_ch.ready;
  assign s4_go    = s4_vld_r && (!s4_lo_r || out_free);
  assign rdy4     = !s4_vld_r || s4_go;
  assign rdy3     = !s3_vld_r || rdy4;
  assign rdy2     = !s2_vld_r || rdy3;
  assign rdy1     = !s1_vld_r || rdy2;

  assign in_ch.ready  = rdy1;
  assign cfg_ch.ready = 1'b1;

  // seconds from sector plus offset
  assign sec_prod = cddb_pkg::sec_prod_t'(s1_sum_r) *
                    cddb_pkg::sec_prod_t'(cddb_pkg::SEC_RECIP);

  // hundreds and ten-thousands of the seconds
  assign hund_prod = cddb_pkg::dec_prod_t'(s2_sec_r) *
                     cddb_pkg::dec_prod_t'(cddb_pkg::HUND_RECIP);
  assign myr_prod  = cddb_pkg::dec_prod_t'(s2_sec_r) *
                     cddb_pkg::dec_prod_t'(cddb_pkg::MYR_RECIP);

  // two-digit groups and their digit sums
  assign dig_lo  = cddb_pkg::dig2_t'(cddb_pkg::wk_t'(s3_sec_r) -
                   cddb_pkg::wk_t'(s3_hund_r) * cddb_pkg::wk_t'(cddb_pkg::DEC_HUNDRED));
  assign dig_mid = cddb_pkg::dig2_t'(cddb_pkg::wk_t'(s3_hund_r) -
                   cddb_pkg::wk_t'(s3_myr_r) * cddb_pkg::wk_t'(cddb_pkg::DEC_HUNDRED));
  assign dsum    = cddb_pkg::dsum_t'(cddb_pkg::digit_sum2(dig_lo)) +
                   cddb_pkg::dsum_t'(cddb_pkg::digit_sum2(dig_mid)) +
                   cddb_pkg::dsum_t'(cddb_pkg::digit_sum2(s3_myr_r));

  // digit total mod 255 by folding the high nibble onto the low byte
  assign chk_fold = cddb_pkg::chk_sum_t'(digit_total_r[cddb_pkg::DT_W-1:cddb_pkg::CHK_W]) +
                    cddb_pkg::chk_sum_t'(digit_total_r[cddb_pkg::CHK_W-1:0]);
  assign chk = (chk_fold >= cddb_pkg::chk_sum_t'(cddb_pkg::ID_MODULUS)) ?
               cddb_pkg::chk_t'(chk_fold - cddb_pkg::chk_sum_t'(cddb_pkg::ID_MODULUS)) :
               cddb_pkg::chk_t'(chk_fold);

  // play time wraps modulo 2^16
  assign play = cddb_pkg::play_t'(cddb_pkg::pw_t'(s4_sec_r) - cddb_pkg::pw_t'(first_sec_r));

  // per-disc state update and packed identifier
  always_comb begin
    digit_total_nxt = digit_total_r;
    first_sec_nxt   = first_sec_r;
    track_count_nxt = track_count_r;
    too_many_nxt    = too_many_r;
    out_id_nxt      = '0;
    if (track_count_r != '0) begin
      out_id_nxt = {chk, play, cddb_pkg::chk_t'(track_count_r)};
    end
    if (s4_go) begin
      if (s4_lo_r) begin
        digit_total_nxt = '0;
        first_sec_nxt   = '0;
        track_count_nxt = '0;
        too_many_nxt    = 1'b0;
      end else if (track_count_r >= cddb_pkg::count_t'(cddb_pkg::MAX_TRACKS)) begin
        too_many_nxt = 1'b1;
      end else begin
        if (track_count_r == '0) first_sec_nxt = cddb_pkg::first_t'(s4_sec_r);
        digit_total_nxt = digit_total_r + cddb_pkg::dt_t'(s4_dsum_r);
        track_count_nxt = track_count_r + cddb_pkg::count_t'(1);
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r      <= '0;
      s1_vld_r      <= 1'b0;
      s2_vld_r      <= 1'b0;
      s3_vld_r      <= 1'b0;
      s4_vld_r      <= 1'b0;
      digit_total_r <= '0;
      first_sec_r   <= '0;
      track_count_r <= '0;
      too_many_r    <= 1'b0;
      out_vld_r     <= 1'b0;
    end else begin
      if (cfg_ch.valid) offset_r <= cfg_ch.sector_offset;
      if (rdy1) s1_vld_r <= in_ch.valid;
      if (rdy2) s2_vld_r <= s1_vld_r;
      if (rdy3) s3_vld_r <= s2_vld_r;
      if (rdy4) s4_vld_r <= s3_vld_r;
      digit_total_r <= digit_total_nxt;
      first_sec_r   <= first_sec_nxt;
      track_count_r <= track_count_nxt;
      too_many_r    <= too_many_nxt;
      if (s4_go && s4_lo_r) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // stage payloads and result beat
  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_lo_r  <= in_ch.is_leadout;
      s1_sum_r <= cddb_pkg::sum_t'(in_ch.start_sector) + cddb_pkg::sum_t'(offset_r);
    end
    if (rdy2) begin
      s2_lo_r  <= s1_lo_r;
      s2_sec_r <= cddb_pkg::sec_t'(sec_prod >> cddb_pkg::SEC_SHIFT);
    end
    if (rdy3) begin
      s3_lo_r   <= s2_lo_r;
      s3_sec_r  <= s2_sec_r;
      s3_hund_r <= cddb_pkg::hund_t'(hund_prod >> cddb_pkg::HUND_SHIFT);
      s3_myr_r  <= cddb_pkg::dig2_t'(myr_prod >> cddb_pkg::MYR_SHIFT);
    end
    if (rdy4) begin
      s4_lo_r   <= s3_lo_r;
      s4_sec_r  <= s3_sec_r;
      s4_dsum_r <= dsum;
    end
    if (s4_go && s4_lo_r) begin
      out_id_r    <= out_id_nxt;
      out_total_r <= track_count_r;
      out_ovf_r   <= too_many_r;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.disc_id     = out_id_r;
  assign out_ch.track_total = out_total_r;
  assign out_ch.overflow    = out_ovf_r;

endmodule

`default_nettype wire

@@ tb/sv/cddb_disc_id_checker.sv @@
// cddb_disc_id_checker: watches the cfg, toc-entry and result channels of cddb_disc_id,
// predicts each disc identifier and compares it field by field with the result beats
// depends on cddb_pkg
`timescale 1ns / 100ps

module cddb_disc_id_checker
  import cddb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  offset_t     cfg_sector_offset,
  input  logic        in_valid,
  input  logic        in_ready,
  input  sector_t     in_start_sector,
  input  logic        in_is_leadout,
  input  logic        out_valid,
  input  logic        out_ready,
  input  id_t         out_disc_id,
  input  count_t      out_track_total,
  input  logic        out_overflow,
  output int unsigned fail_count,
  output int unsigned ids_pending
);

  typedef struct packed {
    id_t    disc_id;
    count_t track_total;
    logic   overflow;
  } disc_result_t;

  // mirror of the block's per-disc state and its offset register
  offset_t        offset_reg;
  logic [11:0]    digit_acc;
  logic [12:0]    first_secs;
  logic [6:0]     tracks_seen;
  logic           extra_tracks;
  disc_result_t   expected_ids[$];

  initial begin
    fail_count  = 0;
    ids_pending = 0;
  end

  function automatic logic [12:0] sector_seconds(sector_t sector);
    logic [19:0] total;
    total = 20'(sector) + 20'(offset_reg);
    return 13'(total / 20'(SECTORS_PER_SECOND));
  endfunction

  function automatic logic [5:0] sum_of_digits(logic [12:0] v);
    logic [12:0] rest;
    logic [5:0]  acc;
    rest = v;
    acc  = '0;
    while (rest != 0) begin
      acc  = acc + 6'(rest % 13'd10);
      rest = rest / 13'd10;
    end
    return acc;
  endfunction

  function automatic void forget_disc();
    digit_acc    = '0;
    first_secs   = '0;
    tracks_seen  = '0;
    extra_tracks = 1'b0;
  endfunction

  // fold one toc entry into the disc state; a lead-out queues the identifier
  function automatic void tally_toc_entry(sector_t sector, logic leadout);
    logic [12:0]  secs;
    logic [15:0]  play;
    disc_result_t res;
    secs = sector_seconds(sector);
    if (!leadout) begin
      if (32'(tracks_seen) >= MAX_TRACKS) begin
        extra_tracks = 1'b1;
      end else begin
        if (tracks_seen == 0) first_secs = secs;
        digit_acc   = digit_acc + 12'(sum_of_digits(secs));
        tracks_seen = tracks_seen + 7'd1;
      end
    end else begin
      res.disc_id = '0;
      if (tracks_seen != 0) begin
        play = 16'(32'(secs) - 32'(first_secs));
        res.disc_id = (32'(digit_acc % 12'(ID_MODULUS)) << 24) | (32'(play) << 8)
                      | 32'(tracks_seen);
      end
      res.track_total = tracks_seen;
      res.overflow    = extra_tracks;
      expected_ids.push_back(res);
      forget_disc();
    end
  endfunction

  // compare one result beat with the oldest expected identifier
  function automatic void check_result();
    disc_result_t want;
    if (expected_ids.size() == 0) begin
      $display("%0t: result beat with nothing expected, actual id %h count %0d ovf %b",
               $time, out_disc_id, out_track_total, out_overflow);
      fail_count++;
      return;
    end
    want = expected_ids.pop_front();
    if (out_disc_id !== want.disc_id) begin
      $display("%0t: disc_id mismatch, expected %h actual %h",
               $time, want.disc_id, out_disc_id);
      fail_count++;
    end
    if (out_track_total !== want.track_total) begin
      $display("%0t: track_total mismatch, expected %0d actual %0d",
               $time, want.track_total, out_track_total);
      fail_count++;
    end
    if (out_overflow !== want.overflow) begin
      $display("%0t: overflow mismatch, expected %b actual %b",
               $time, want.overflow, out_overflow);
      fail_count++;
    end
  endfunction

  // sample all channels on the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      offset_reg = '0;
      forget_disc();
      expected_ids.delete();
    end else begin
      if (out_valid && out_ready) check_result();
      if (cfg_valid && cfg_ready) offset_reg = cfg_sector_offset;
      if (in_valid && in_ready) tally_toc_entry(in_start_sector, in_is_leadout);
    end
    ids_pending = expected_ids.size();
  end

endmodule

@@ tb/sv/tb_cddb_disc_id.sv @@
// tb_cddb_disc_id: drives toc entries and offset writes into cddb_disc_id with random
// gaps and result stalls; the verdict comes from cddb_disc_id_checker
// depends on cddb_pkg, the cddb channel interfaces, cddb_disc_id and the checker
`timescale 1ns / 100ps

module tb_cddb_disc_id;
  import cddb_pkg::*;

  localparam int RANDOM_ENTRIES = 1850;
  localparam int PHASE_ENTRIES  = 300;
  localparam int DRAIN_CYCLES   = 16;
  localparam int MAX_SECTOR     = 449999;
  localparam int MAX_OFFSET     = 450;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned ids_pending;
  int unsigned entries_sent;
  bit          steady_feed;
  bit          steady_drain;
  int unsigned ids_taken;

  cddb_cfg_if cfg_ch();
  cddb_in_if  in_ch();
  cddb_out_if out_ch();

  cddb_disc_id i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cddb_disc_id_checker i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_ch.valid),
    .cfg_ready         (cfg_ch.ready),
    .cfg_sector_offset (cfg_ch.sector_offset),
    .in_valid          (in_ch.valid),
    .in_ready          (in_ch.ready),
    .in_start_sector   (in_ch.start_sector),
    .in_is_leadout     (in_ch.is_leadout),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_disc_id       (out_ch.disc_id),
    .out_track_total   (out_ch.track_total),
    .out_overflow      (out_ch.overflow),
    .fail_count        (fail_count),
    .ids_pending       (ids_pending)
  );

  // 12 ns clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // send one toc entry; called and returns at a falling edge
  task automatic feed_entry(input int sector, input bit leadout);
    int gap;
    gap = steady_feed ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.start_sector = sector_t'(sector);
    in_ch.is_leadout   = leadout;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    entries_sent++;
  endtask

  // write the offset register once every disc in flight has come back
  task automatic set_sector_offset(input int value);
    in_ch.valid = 1'b0;
    while (ids_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_ch.valid         = 1'b1;
    cfg_ch.sector_offset = offset_t'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // one disc: mostly ascending tracks, sometimes empty, overfull or scrambled
  task automatic random_disc();
    int pick;
    int tracks;
    int pos;
    int step_max;
    bit scrambled;
    pick = $urandom_range(0, 99);
    if (pick < 5) tracks = 0;
    else if (pick < 10) tracks = $urandom_range(MAX_TRACKS - 1, MAX_TRACKS + 3);
    else tracks = $urandom_range(1, 25);
    scrambled   = ($urandom_range(0, 7) == 0);
    steady_feed = ($urandom_range(0, 4) == 0);
    step_max    = MAX_SECTOR / (tracks + 1);
    pos         = $urandom_range(0, 30000);
    for (int t = 0; t < tracks; t++) begin
      if (scrambled) begin
        feed_entry($urandom_range(0, MAX_SECTOR), 1'b0);
      end else begin
        feed_entry(pos, 1'b0);
        pos = pos + $urandom_range(1, step_max);
        if (pos > MAX_SECTOR) pos = MAX_SECTOR;
      end
    end
    feed_entry(scrambled ? $urandom_range(0, MAX_SECTOR) : pos, 1'b1);
  endtask

  // result side: random stall before each beat, with calm stretches
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    steady_drain = 1'b0;
    ids_taken    = 0;
    forever begin
      @(negedge clk);
      stall = steady_drain ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      ids_taken++;
      if (ids_taken % 16 == 0) steady_drain = ($urandom_range(0, 3) == 0);
    end
  end

  // reset, directed discs, then random phases across offset settings
  initial begin
    int phase;
    int phase_start;
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.start_sector   = '0;
    in_ch.is_leadout     = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.sector_offset = '0;
    entries_sent         = 0;
    steady_feed          = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // offset at its reset value: empty disc, extremes, wrap of play time
    feed_entry(0, 1'b1);
    feed_entry(0, 1'b0);
    feed_entry(MAX_SECTOR, 1'b1);
    feed_entry(MAX_SECTOR, 1'b0);
    feed_entry(0, 1'b1);
    feed_entry(74, 1'b0);
    feed_entry(75, 1'b0);
    feed_entry(262144, 1'b0);
    feed_entry(449925, 1'b0);
    feed_entry(MAX_SECTOR, 1'b1);
    feed_entry(MAX_SECTOR, 1'b1);

    // largest offset
    set_sector_offset(MAX_OFFSET);
    feed_entry(MAX_SECTOR, 1'b0);
    feed_entry(0, 1'b0);
    feed_entry(MAX_SECTOR, 1'b1);
    feed_entry(0, 1'b1);

    // standard offset
    set_sector_offset(150);
    feed_entry(0, 1'b0);
    feed_entry(32, 1'b0);
    feed_entry(4500, 1'b1);

    // random discs, offset changed between phases
    phase = 0;
    entries_sent = 0;
    while (entries_sent < RANDOM_ENTRIES) begin
      case (phase % 5)
        0: set_sector_offset(150);
        1: set_sector_offset($urandom_range(0, MAX_OFFSET));
        2: set_sector_offset(0);
        3: set_sector_offset(MAX_OFFSET);
        default: set_sector_offset($urandom_range(1, MAX_OFFSET - 1));
      endcase
      phase_start = entries_sent;
      while (entries_sent - phase_start < PHASE_ENTRIES && entries_sent < RANDOM_ENTRIES)
        random_disc();
      phase++;
    end
    in_ch.valid = 1'b0;

    // drain and verdict
    while (ids_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
